// ----- hdl/kml_pkg.sv -----
package kml_pkg;

  localparam int MaxClusters = 16;
  localparam int MaxDims = 16;
  localparam int ValueBits = 16;
  localparam int ClBits = 4;
  localparam int DmBits = 4;
  localparam int AddrBits = ClBits + DmBits;
  localparam int DistBits = 36;
  localparam int SumBits = 40;
  localparam int CountBits = 16;
  localparam int TolBits = 40;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRAIN = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY = 2'd2;
  localparam logic [1:0] ACT_END = 2'd3;

  localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] CFG_NUM_DIMS = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [DistBits-1:0] DIST_CAP = {DistBits{1'b1}};

  // Classified command passed from front to back.
  typedef struct packed {
    logic [1:0]                  op;
    logic [ClBits-1:0]           cluster;
    logic [DmBits-1:0]           dim;
    logic signed [ValueBits-1:0] value;
  } cmd_t;

  // Squared difference of two elements; the square of a 17-bit magnitude
  // always fits below DIST_CAP.
  function automatic logic [DistBits-1:0] sq_diff(input logic signed [ValueBits-1:0] a,
                                                  input logic signed [ValueBits-1:0] b);
    logic signed [ValueBits:0] df;
    logic [ValueBits:0] ad;
    logic [2*ValueBits+1:0] sq;
    begin
      df = {a[ValueBits-1], a} - {b[ValueBits-1], b};
      ad = df[ValueBits] ? (ValueBits+1)'(0) - df : df;
      sq = ad * ad;
      sq_diff = {{(DistBits-2*ValueBits-2){1'b0}}, sq};
    end
  endfunction

endpackage

// ----- hdl/kml_front.sv -----
// Front: decodes and filters input words, writes the cmd queue.
module kml_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [kml_pkg::ClBits-1:0]      cluster,
  input  logic [kml_pkg::DmBits-1:0]      dim,
  input  logic signed [kml_pkg::ValueBits-1:0] value,
  input  logic [kml_pkg::DmBits:0]        eff_d,
  output logic                            q_valid,
  output kml_pkg::cmd_t                   q_cmd,
  input  logic                            q_pop
);
  import kml_pkg::*;

  localparam int Depth = 4;
  cmd_t fifo [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic push, keep;

  // Out-of-range sample elements are dropped here.
  always_comb begin
    keep = 1'b1;
    if ((action == ACT_TRAIN || action == ACT_CLASSIFY) &&
        ({1'b0, dim} >= eff_d)) keep = 1'b0;
  end

  assign in_stall = (count == 3'(Depth));
  assign push = in_valid && !in_stall && keep;
  assign q_valid = (count != 3'd0);
  assign q_cmd = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= '{op: action, cluster: cluster, dim: dim, value: value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(q_pop);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop of empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 3'(Depth))
    else $error("queue overflow");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    (count == 3'(Depth)) |-> in_stall) else $error("stall missing when full");

endmodule

// ----- hdl/kml_divider.sv -----
// Restoring divider: signed 40-bit dividend by unsigned 16-bit count, truncating.
module kml_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [kml_pkg::SumBits-1:0]  dividend,
  input  logic [kml_pkg::CountBits-1:0]       divisor,
  output logic                                busy,
  output logic                                done,
  output logic signed [kml_pkg::SumBits-1:0]  quotient
);
  import kml_pkg::*;

  logic [SumBits-1:0] mag, quo;
  logic [CountBits:0] rem;
  logic [CountBits-1:0] dvs;
  logic neg;
  logic [5:0] step;
  logic [CountBits+1:0] trial;

  always_comb begin
    trial = {1'b0, rem[CountBits-1:0], mag[SumBits-1]} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'(SumBits);
      end else if (busy) begin
        step <= step - 6'd1;
        if (step == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SumBits-1];
      mag <= dividend[SumBits-1] ? SumBits'(0) - dividend : dividend;
      rem <= '0;
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      mag <= {mag[SumBits-2:0], 1'b0};
      if (!trial[CountBits+1]) begin
        rem <= trial[CountBits:0];
        quo <= {quo[SumBits-2:0], 1'b1};
      end else begin
        rem <= {rem[CountBits-1:0], mag[SumBits-1]};
        quo <= {quo[SumBits-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? SumBits'(0) - quo : quo;

endmodule

// ----- hdl/kml_back.sv -----
// Back: executes commands against centroid, sum and count stores.
module kml_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  kml_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  input  logic [kml_pkg::ClBits:0]         eff_k,
  input  logic [kml_pkg::DmBits:0]         eff_d,
  input  logic [kml_pkg::TolBits-1:0]      tol,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic [kml_pkg::ClBits-1:0]       label,
  output logic [kml_pkg::DistBits-1:0]     distance_sq,
  output logic [kml_pkg::DistBits-1:0]     max_shift_sq,
  output logic                             converged
);
  import kml_pkg::*;

  localparam int Entries = MaxClusters * MaxDims;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRCH    = 4'd1;  // read centroid element
  localparam logic [3:0] S_SACC    = 4'd2;  // accumulate distance
  localparam logic [3:0] S_TRN_RD  = 4'd3;
  localparam logic [3:0] S_TRN_WR  = 4'd4;
  localparam logic [3:0] S_OUT     = 4'd5;
  localparam logic [3:0] S_END_RD  = 4'd6;
  localparam logic [3:0] S_END_DIV = 4'd7;
  localparam logic [3:0] S_END_WT  = 4'd8;
  localparam logic [3:0] S_END_WR  = 4'd9;
  localparam logic [3:0] S_CLR     = 4'd10;
  localparam logic [3:0] S_TRN_RD_W = 4'd11;  // sum read in flight

  logic [3:0] state;

  logic signed [ValueBits-1:0] cent_mem [Entries];
  logic signed [SumBits-1:0]   sum_mem  [Entries];
  logic signed [ValueBits-1:0] samp     [MaxDims];
  logic [CountBits-1:0]        counts   [MaxClusters];
  logic [MaxClusters-1:0]      cnt_valid;

  logic [ClBits:0] ci;
  logic [DmBits:0] di;
  logic [ClBits-1:0] best;
  logic [DistBits-1:0] bestd, acc, maxs;
  logic is_train;
  logic [AddrBits:0] clr_idx;

  logic signed [ValueBits-1:0] cent_rd;
  logic signed [SumBits-1:0] sum_rd;
  logic [AddrBits-1:0] addr;
  logic signed [ValueBits-1:0] mean;
  logic [CountBits-1:0] cur_cnt;

  logic div_start, div_busy, div_done;
  logic signed [SumBits-1:0] div_q;

  logic [DistBits:0] acc_sum;
  logic signed [SumBits:0] sum_add;
  logic signed [SumBits-1:0] sum_sat;

  assign addr = {ci[ClBits-1:0], di[DmBits-1:0]};
  assign cur_cnt = cnt_valid[ci[ClBits-1:0]] ? counts[ci[ClBits-1:0]] : '0;

  kml_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_rd),
    .divisor(cur_cnt), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    if (div_q > SumBits'(signed'({1'b0, {(ValueBits-1){1'b1}}})))
      mean = {1'b0, {(ValueBits-1){1'b1}}};
    else if (div_q < -SumBits'(signed'({1'b0, {(ValueBits-1){1'b1}}})) - SumBits'(1))
      mean = {1'b1, {(ValueBits-1){1'b0}}};
    else
      mean = div_q[ValueBits-1:0];
  end

  // Search compares the sample element; end of pass compares the new mean.
  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, sq_diff(state == S_SACC ? samp[di[DmBits-1:0]] : mean,
                                           cent_rd)};
    sum_add = {sum_rd[SumBits-1], sum_rd} +
              (SumBits+1)'(signed'(samp[di[DmBits-1:0]]));
    if (sum_add[SumBits] != sum_add[SumBits-1])
      sum_sat = sum_add[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                                 : {1'b0, {(SumBits-1){1'b1}}};
    else
      sum_sat = sum_add[SumBits-1:0];
  end

  assign div_start = (state == S_END_DIV);
  assign q_pop = q_valid && (state == S_IDLE) &&
                 !(q_cmd.op != ACT_LOAD && out_valid);

  // Centroid memory
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == ACT_LOAD)
      cent_mem[{q_cmd.cluster, q_cmd.dim}] <= q_cmd.value;
    else if (state == S_END_WR)
      cent_mem[addr] <= mean;
    cent_rd <= cent_mem[addr];
  end

  // Sum memory; the clear sweep zeroes it after reset and after each pass
  always_ff @(posedge clk) begin
    if (state == S_TRN_WR) sum_mem[addr] <= sum_sat;
    else if (state == S_CLR) sum_mem[clr_idx[AddrBits-1:0]] <= '0;
    sum_rd <= sum_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == ACT_TRAIN || q_cmd.op == ACT_CLASSIFY))
      samp[q_cmd.dim] <= q_cmd.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      cnt_valid <= '0;
      out_valid <= 1'b0;
      ci <= '0;
      di <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            is_train <= (q_cmd.op == ACT_TRAIN);
            ci <= '0;
            di <= '0;
            acc <= '0;
            maxs <= '0;
            if (q_cmd.op == ACT_END) state <= S_END_RD;
            else if (q_cmd.op != ACT_LOAD && {1'b0, q_cmd.dim} == eff_d - 1'b1)
              state <= S_SRCH;
          end
        end
        S_SRCH: state <= S_SACC;
        S_SACC: begin
          if (di == eff_d - 1'b1) begin
            if (ci == '0 || acc_sum[DistBits-1:0] < bestd || acc_sum[DistBits]) begin
              if (ci == '0 || (!acc_sum[DistBits] && acc_sum[DistBits-1:0] < bestd)) begin
                best <= ci[ClBits-1:0];
                bestd <= acc_sum[DistBits] ? DIST_CAP : acc_sum[DistBits-1:0];
              end
            end
            acc <= '0;
            di <= '0;
            if (ci == eff_k - 1'b1) begin
              state <= S_TRN_RD;
              ci <= '0;
            end else begin
              ci <= ci + 1'b1;
              state <= S_SRCH;
            end
          end else begin
            acc <= acc_sum[DistBits] ? DIST_CAP : acc_sum[DistBits-1:0];
            di <= di + 1'b1;
            state <= S_SRCH;
          end
        end
        S_TRN_RD: begin
          ci <= {1'b0, best};
          if (is_train && !(cnt_valid[best] && counts[best] == {CountBits{1'b1}})) begin
            state <= S_TRN_RD_W;
            counts[best] <= (cnt_valid[best] ? counts[best] : '0) + 1'b1;
            cnt_valid[best] <= 1'b1;
          end else state <= S_OUT;
        end
        S_TRN_RD_W: state <= S_TRN_WR;
        S_TRN_WR: begin
          // sum_rd holds the entry addressed in the previous cycle
          if (di == eff_d - 1'b1) begin
            di <= '0;
            state <= S_OUT;
          end else begin
            di <= di + 1'b1;
            state <= S_TRN_RD_W;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          kind <= 1'b0;
          label <= best;
          distance_sq <= bestd;
          max_shift_sq <= '0;
          converged <= 1'b0;
          state <= S_IDLE;
        end
        S_END_RD: begin
          if (ci == eff_k) begin
            out_valid <= 1'b1;
            kind <= 1'b1;
            label <= '0;
            distance_sq <= '0;
            max_shift_sq <= maxs;
            converged <= ({{(TolBits-DistBits){1'b0}}, maxs} < tol);
            cnt_valid <= '0;
            clr_idx <= '0;
            state <= S_CLR;
          end else if (cur_cnt == '0) begin
            ci <= ci + 1'b1;
          end else state <= S_END_DIV;
        end
        S_END_DIV: state <= S_END_WT;
        S_END_WT: if (div_done) state <= S_END_WR;
        S_END_WR: begin
          if (di == eff_d - 1'b1) begin
            if (acc_sum[DistBits] || acc_sum[DistBits-1:0] > maxs)
              maxs <= (acc_sum[DistBits] ? DIST_CAP : acc_sum[DistBits-1:0]) > maxs ?
                      (acc_sum[DistBits] ? DIST_CAP : acc_sum[DistBits-1:0]) : maxs;
            acc <= '0;
            di <= '0;
            ci <= ci + 1'b1;
            state <= S_END_RD;
          end else begin
            // next element's sum is read in S_END_RD before the divider starts
            acc <= acc_sum[DistBits] ? DIST_CAP : acc_sum[DistBits-1:0];
            di <= di + 1'b1;
            state <= S_END_RD;
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (AddrBits+1)'(Entries - 1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop while busy");
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_END_WT) else $error("divider result unexpected");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider started while busy");

endmodule

// ----- hdl/kmeans_lloyd_engine.sv -----
// Lloyd k-means engine, Q8.8; each input word passes through the front queue.
// Back end: a load or non-final sample element is stored; the final element of a
// sample starts a search over all k clusters, and a train sample also adds into its cluster's sums.
// End of pass: each element sum of each non-empty cluster is divided by its count (40-step
// divider), empty clusters are skipped, then the result, then a clear sweep of all 256 sums.
// Reset (rst, synchronous): registers to 2, 2, 1; counts empty; queue empty; same sweep.
module kmeans_lloyd_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            action,
  input  logic [kml_pkg::ClBits-1:0]            cluster,
  input  logic [kml_pkg::DmBits-1:0]            dim,
  input  logic signed [kml_pkg::ValueBits-1:0]  value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  kind,
  output logic [kml_pkg::ClBits-1:0]            label,
  output logic [kml_pkg::DistBits-1:0]          distance_sq,
  output logic [kml_pkg::DistBits-1:0]          max_shift_sq,
  output logic                                  converged,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [kml_pkg::TolBits-1:0]           cfg_data
);
  import kml_pkg::*;

  logic [4:0] num_clusters, num_dims;
  logic [TolBits-1:0] tolerance_sq;
  logic [ClBits:0] eff_k;
  logic [DmBits:0] eff_d;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 5'd2;
      num_dims <= 5'd2;
      tolerance_sq <= TolBits'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[4:0];
        CFG_NUM_DIMS: num_dims <= cfg_data[4:0];
        CFG_TOLERANCE: tolerance_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp k and d to 1..16
  always_comb begin
    eff_k = (num_clusters == 5'd0) ? 5'd1 : (num_clusters > 5'd16 ? 5'd16 : num_clusters);
    eff_d = (num_dims == 5'd0) ? 5'd1 : (num_dims > 5'd16 ? 5'd16 : num_dims);
  end

  kml_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .cluster(cluster), .dim(dim), .value(value),
    .eff_d(eff_d), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  kml_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .eff_k(eff_k), .eff_d(eff_d), .tol(tolerance_sq),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .label(label),
    .distance_sq(distance_sq), .max_shift_sq(max_shift_sq), .converged(converged)
  );

endmodule
